// ===== rtl/core/rspo_pkg.sv =====
// ============================================================================
// rspo_pkg: shared definitions of the rotated shape pixel occluder
// Field widths, occluder shape codes, register indexes and the pixel
// payload that travels alongside the pipeline.
// ============================================================================
`default_nettype none

package rspo_pkg;

  // Default geometry of the coordinate and fixed-point formats.
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 14;

  // Fixed field widths.
  localparam int OFFSET_W  = 14;
  localparam int TRIG_W    = 16;
  localparam int COLOUR_W  = 8;
  localparam int SHAPE_W   = 3;
  localparam int CFG_IDX_W = 3;

  // Occluder shape codes.
  localparam logic [SHAPE_W-1:0] SHAPE_NONE    = 3'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_BAND    = 3'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_DISC    = 3'd2;
  localparam logic [SHAPE_W-1:0] SHAPE_ELLIPSE = 3'd3;
  localparam logic [SHAPE_W-1:0] SHAPE_SQUARE  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_PX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COS_ROT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_ROT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_A    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_B    = 3'd7;

  // Colour and mask of one pixel, carried unchanged down the pipeline.
  typedef struct packed {
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
    logic                mask;
  } pix_t;

endpackage

`default_nettype wire

// ===== rtl/core/rotated_shape_pixel_occluder_unit.sv =====
// ============================================================================
// rotated_shape_pixel_occluder_unit: blackens foreground pixels under a shape
// Rotates each pixel about the shape origin and tests it against a band,
// disc, ellipse or square; masked pixels inside the shape are blackened.
// ============================================================================
// Usage
//   A pixel word is taken at a rising edge where start is high and busy is
//   low. busy is low whenever reset is released, so one pixel can be taken
//   in every clock cycle.
//   Each pixel gives exactly one result word, shown on the out_ ports for a
//   single cycle with out_valid high. Results leave in the order the pixels
//   came in. The receiver cannot hold results off, so the pipeline never
//   stalls.
//   The pipeline has six register stages: origin distance, rotation
//   products, rounding, squares, cross products and the final compare.
//   Throughput is one pixel per cycle at all times.
//   The configuration port writes register cfg_index at any edge where
//   cfg_we is high out of reset. It must only be written while no pixel is
//   in flight. Synchronous reset empties the pipeline and sets every
//   configuration register to zero, except the cosine, which becomes one.
// ============================================================================
`default_nettype none

module rotated_shape_pixel_occluder_unit #(
  parameter int COORD_BITS = rspo_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rspo_pkg::FRAC_BITS_DEF,
  localparam int CFG_DW    = (COORD_BITS > rspo_pkg::TRIG_W) ? COORD_BITS
                                                             : rspo_pkg::TRIG_W
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [COORD_BITS-1:0]            in_pixel_x,
  input  logic [COORD_BITS-1:0]            in_pixel_y,
  input  logic [rspo_pkg::COLOUR_W-1:0]    in_red_in,
  input  logic [rspo_pkg::COLOUR_W-1:0]    in_green_in,
  input  logic [rspo_pkg::COLOUR_W-1:0]    in_blue_in,
  input  logic                             in_mask_in,
  output logic                             out_valid,
  output logic [rspo_pkg::COLOUR_W-1:0]    out_red_out,
  output logic [rspo_pkg::COLOUR_W-1:0]    out_green_out,
  output logic [rspo_pkg::COLOUR_W-1:0]    out_blue_out,
  output logic                             out_mask_out,
  output logic                             out_was_blocked,
  input  logic                             cfg_we,
  input  logic [rspo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]                cfg_wdata
);
  import rspo_pkg::*;

  localparam int AW  = COORD_BITS + 1;      // rotated magnitude
  localparam int BW  = COORD_BITS + 2;      // doubled magnitude
  localparam int QW  = 2 * COORD_BITS + 1;  // squared magnitude
  localparam int QA  = 2 * COORD_BITS;      // squared size
  localparam int DSW = QW + 1;              // disc sum
  localparam int EW  = QW + QA;             // ellipse cross product
  localparam int ESW = EW + 1;              // ellipse sum
  localparam int LAT = 6;                   // accept edge to result edge
  localparam logic [TRIG_W-1:0] COS_RESET = TRIG_W'(1 << FRAC_BITS);

  // Configuration registers.
  logic [SHAPE_W-1:0]         shape_r;
  logic [COORD_BITS-1:0]      center_x_r;
  logic [COORD_BITS-1:0]      center_y_r;
  logic signed [OFFSET_W-1:0] offset_px_r;
  logic signed [TRIG_W-1:0]   cos_rot_r;
  logic signed [TRIG_W-1:0]   sin_rot_r;
  logic [COORD_BITS-1:0]      size_a_r;
  logic [COORD_BITS-1:0]      size_b_r;

  logic                  in_take;
  pix_t                  in_pix;
  logic                  rot_valid;
  logic [AW-1:0]         abs_x;
  logic [AW-1:0]         abs_y;
  pix_t                  rot_pix;

  logic                  s4_valid_r;
  logic [QW-1:0]         ax2_r, ax2_nxt;
  logic [QW-1:0]         ay2_r, ay2_nxt;
  logic [QA-1:0]         a2_r, a2_nxt;
  logic [QA-1:0]         b2_r, b2_nxt;
  logic                  s4_band_r, s4_band_nxt;
  logic                  s4_square_r, s4_square_nxt;
  pix_t                  s4_pix_r;

  logic                  s5_valid_r;
  logic [EW-1:0]         t1_r, t1_nxt;
  logic [EW-1:0]         t2_r, t2_nxt;
  logic [EW-1:0]         lim_r, lim_nxt;
  logic                  s5_disc_r, s5_disc_nxt;
  logic                  s5_ezero_r, s5_ezero_nxt;
  logic                  s5_band_r;
  logic                  s5_square_r;
  pix_t                  s5_pix_r;

  logic                  ell_ok;
  logic                  hit;
  logic                  blocked;
  logic                  out_valid_r;
  pix_t                  out_pix_r, out_pix_nxt;
  logic                  out_blocked_r;

  // The pipeline can take a word in every cycle once out of reset.
  assign busy    = ~rst_n;
  assign in_take = start & ~busy;
  assign in_pix  = '{red: in_red_in, green: in_green_in, blue: in_blue_in,
                     mask: in_mask_in};

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r     <= SHAPE_NONE;
      center_x_r  <= '0;
      center_y_r  <= '0;
      offset_px_r <= '0;
      cos_rot_r   <= COS_RESET;
      sin_rot_r   <= '0;
      size_a_r    <= '0;
      size_b_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHAPE:     shape_r     <= cfg_wdata[SHAPE_W-1:0];
        REG_CENTER_X:  center_x_r  <= cfg_wdata[COORD_BITS-1:0];
        REG_CENTER_Y:  center_y_r  <= cfg_wdata[COORD_BITS-1:0];
        REG_OFFSET_PX: offset_px_r <= cfg_wdata[OFFSET_W-1:0];
        REG_COS_ROT:   cos_rot_r   <= cfg_wdata[TRIG_W-1:0];
        REG_SIN_ROT:   sin_rot_r   <= cfg_wdata[TRIG_W-1:0];
        REG_SIZE_A:    size_a_r    <= cfg_wdata[COORD_BITS-1:0];
        REG_SIZE_B:    size_b_r    <= cfg_wdata[COORD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Stages 1 to 3: rotated and rounded position.
  rspo_rotate #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_take),
    .pixel_x   (in_pixel_x),
    .pixel_y   (in_pixel_y),
    .in_pix    (in_pix),
    .center_x  (center_x_r),
    .center_y  (center_y_r),
    .offset_px (offset_px_r),
    .cos_rot   (cos_rot_r),
    .sin_rot   (sin_rot_r),
    .out_valid (rot_valid),
    .abs_x     (abs_x),
    .abs_y     (abs_y),
    .out_pix   (rot_pix)
  );

  // Stage 4: squares and the straight-edge tests of band and square.
  always_comb begin
    ax2_nxt       = QW'(abs_x) * QW'(abs_x);
    ay2_nxt       = QW'(abs_y) * QW'(abs_y);
    a2_nxt        = QA'(size_a_r) * QA'(size_a_r);
    b2_nxt        = QA'(size_b_r) * QA'(size_b_r);
    s4_band_nxt   = {abs_x, 1'b0} <= BW'(size_a_r);
    s4_square_nxt = s4_band_nxt && ({abs_y, 1'b0} <= BW'(size_a_r));
  end

  // Stage 5: ellipse cross products and the disc test.
  always_comb begin
    t1_nxt       = EW'(ax2_r) * EW'(b2_r);
    t2_nxt       = EW'(ay2_r) * EW'(a2_r);
    lim_nxt      = EW'(a2_r) * EW'(b2_r);
    s5_disc_nxt  = (DSW'(ax2_r) + DSW'(ay2_r)) <= DSW'(a2_r);
    s5_ezero_nxt = (a2_r == '0) || (b2_r == '0);
  end

  // Stage 6: ellipse test, shape selection and blackening.
  always_comb begin
    ell_ok = !s5_ezero_r && ((ESW'(t1_r) + ESW'(t2_r)) <= ESW'(lim_r));
    case (shape_r)
      SHAPE_BAND:    hit = s5_band_r;
      SHAPE_DISC:    hit = s5_disc_r;
      SHAPE_ELLIPSE: hit = ell_ok;
      SHAPE_SQUARE:  hit = s5_square_r;
      default:       hit = 1'b0;
    endcase
    blocked     = s5_pix_r.mask && hit;
    out_pix_nxt = blocked ? '0 : s5_pix_r;
  end

  // Valid bits of stages 4 to 6.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s4_valid_r  <= rot_valid;
      s5_valid_r  <= s4_valid_r;
      out_valid_r <= s5_valid_r;
    end
  end

  // Data registers of stages 4 to 6.
  always_ff @(posedge clk) begin
    ax2_r         <= ax2_nxt;
    ay2_r         <= ay2_nxt;
    a2_r          <= a2_nxt;
    b2_r          <= b2_nxt;
    s4_band_r     <= s4_band_nxt;
    s4_square_r   <= s4_square_nxt;
    s4_pix_r      <= rot_pix;
    t1_r          <= t1_nxt;
    t2_r          <= t2_nxt;
    lim_r         <= lim_nxt;
    s5_disc_r     <= s5_disc_nxt;
    s5_ezero_r    <= s5_ezero_nxt;
    s5_band_r     <= s4_band_r;
    s5_square_r   <= s4_square_r;
    s5_pix_r      <= s4_pix_r;
    out_pix_r     <= out_pix_nxt;
    out_blocked_r <= blocked;
  end

  assign out_valid       = out_valid_r;
  assign out_red_out     = out_pix_r.red;
  assign out_green_out   = out_pix_r.green;
  assign out_blue_out    = out_pix_r.blue;
  assign out_mask_out    = out_pix_r.mask;
  assign out_was_blocked = out_blocked_r;

  // A result word only ever follows a taken pixel.
  a_result_follows_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_take, LAT))
    else $error("result word without a matching input word");

  // Only a foreground pixel can be blocked.
  a_block_needs_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_was_blocked) |-> $past(in_mask_in, LAT))
    else $error("pixel blocked although its mask was clear");

  // With no shape selected nothing is ever blocked.
  a_none_blocks_nothing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (shape_r == SHAPE_NONE)) |-> !out_was_blocked)
    else $error("pixel blocked with no shape selected");

endmodule

`default_nettype wire

// ===== rtl/core/rspo_rotate.sv =====
// ============================================================================
// rspo_rotate: offset, rotation and rounding of the pixel position
// Three register stages: distance from the shape origin, the four rotation
// products, then rounding to whole pixels and saturated magnitudes.
// ============================================================================
`default_nettype none

module rspo_rotate #(
  parameter int COORD_BITS = rspo_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rspo_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic [COORD_BITS-1:0]                 pixel_x,
  input  logic [COORD_BITS-1:0]                 pixel_y,
  input  rspo_pkg::pix_t                        in_pix,
  input  logic [COORD_BITS-1:0]                 center_x,
  input  logic [COORD_BITS-1:0]                 center_y,
  input  logic signed [rspo_pkg::OFFSET_W-1:0]  offset_px,
  input  logic signed [rspo_pkg::TRIG_W-1:0]    cos_rot,
  input  logic signed [rspo_pkg::TRIG_W-1:0]    sin_rot,
  output logic                                  out_valid,
  output logic [COORD_BITS:0]                   abs_x,
  output logic [COORD_BITS:0]                   abs_y,
  output rspo_pkg::pix_t                        out_pix
);
  import rspo_pkg::*;

  localparam int MW = (COORD_BITS > OFFSET_W) ? COORD_BITS : OFFSET_W;
  localparam int DW = MW + 2;           // horizontal distance
  localparam int YW = COORD_BITS + 1;   // vertical distance
  localparam int PW = TRIG_W + DW;      // one rotation product
  localparam int SW = PW + 1;           // sum of two products plus rounding
  localparam int AW = COORD_BITS + 1;   // saturated magnitude
  localparam logic signed [SW-1:0] HALF  = SW'(1) << (FRAC_BITS - 1);
  localparam logic [SW-1:0]        LIMIT = SW'(1) << COORD_BITS;

  // Round to the nearest pixel with ties upwards, then take the magnitude,
  // saturated at one more than the largest coordinate.
  function automatic logic [AW-1:0] round_mag(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] q;
    logic [SW-1:0]        m;
    q = (v + HALF) >>> FRAC_BITS;
    m = q[SW-1] ? $unsigned(-q) : $unsigned(q);
    if (m > LIMIT) begin
      round_mag = AW'(LIMIT);
    end else begin
      round_mag = AW'(m);
    end
  endfunction

  logic                 s1_valid_r;
  logic signed [DW-1:0] dx_r, dx_nxt;
  logic signed [YW-1:0] dy_r, dy_nxt;
  pix_t                 s1_pix_r;

  logic                 s2_valid_r;
  logic signed [PW-1:0] cdx_r, cdx_nxt;
  logic signed [PW-1:0] sdy_r, sdy_nxt;
  logic signed [PW-1:0] cdy_r, cdy_nxt;
  logic signed [PW-1:0] sdx_r, sdx_nxt;
  pix_t                 s2_pix_r;

  logic                 s3_valid_r;
  logic signed [SW-1:0] rx_sum, ry_sum;
  logic [AW-1:0]        abs_x_r, abs_x_nxt;
  logic [AW-1:0]        abs_y_r, abs_y_nxt;
  pix_t                 s3_pix_r;

  // Stage 1: distance of the pixel from the shape origin.
  always_comb begin
    dx_nxt = $signed(DW'(pixel_x)) - $signed(DW'(center_x)) - DW'(offset_px);
    dy_nxt = $signed(YW'(pixel_y)) - $signed(YW'(center_y));
  end

  // Stage 2: the four products of the rotation.
  always_comb begin
    cdx_nxt = PW'(cos_rot) * PW'(dx_r);
    sdy_nxt = PW'(sin_rot) * PW'(dy_r);
    cdy_nxt = PW'(cos_rot) * PW'(dy_r);
    sdx_nxt = PW'(sin_rot) * PW'(dx_r);
  end

  // Stage 3: rotated coordinates, rounded and reduced to magnitudes.
  always_comb begin
    rx_sum    = SW'(cdx_r) + SW'(sdy_r);
    ry_sum    = SW'(cdy_r) - SW'(sdx_r);
    abs_x_nxt = round_mag(rx_sum);
    abs_y_nxt = round_mag(ry_sum);
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // Data registers of the three stages.
  always_ff @(posedge clk) begin
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    s1_pix_r <= in_pix;
    cdx_r    <= cdx_nxt;
    sdy_r    <= sdy_nxt;
    cdy_r    <= cdy_nxt;
    sdx_r    <= sdx_nxt;
    s2_pix_r <= s1_pix_r;
    abs_x_r  <= abs_x_nxt;
    abs_y_r  <= abs_y_nxt;
    s3_pix_r <= s2_pix_r;
  end

  assign out_valid = s3_valid_r;
  assign abs_x     = abs_x_r;
  assign abs_y     = abs_y_r;
  assign out_pix   = s3_pix_r;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb: testbench of the rotated shape pixel occluder unit
// Drives pixel words into the unit and predicts each result from its own
// copy of the shape registers: the pixel is rotated about the shape origin
// and tested against the band, disc, ellipse or square. Directed tests cover
// the boundaries and special cases. Random scenes follow, with most pixels
// aimed near the shape. Every result word is checked against the oldest
// prediction.
// ============================================================================

module tb;

  import rspo_pkg::*;

  localparam int CW   = COORD_BITS_DEF;
  localparam int FRAC = FRAC_BITS_DEF;
  localparam int SAT  = 1 << CW;

  // Shape codes with no occluder behind them.
  localparam logic [SHAPE_W-1:0] SHAPE_SPARE_LO = 3'd5;
  localparam logic [SHAPE_W-1:0] SHAPE_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [CW-1:0]       x;
    logic [CW-1:0]       y;
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
    logic                mask;
  } pixel_word_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
    logic                mask;
    logic                blocked;
  } shaded_word_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [CW-1:0]       in_pixel_x;
  logic [CW-1:0]       in_pixel_y;
  logic [COLOUR_W-1:0] in_red_in;
  logic [COLOUR_W-1:0] in_green_in;
  logic [COLOUR_W-1:0] in_blue_in;
  logic                in_mask_in;
  logic                out_valid;
  logic [COLOUR_W-1:0] out_red_out;
  logic [COLOUR_W-1:0] out_green_out;
  logic [COLOUR_W-1:0] out_blue_out;
  logic                out_mask_out;
  logic                out_was_blocked;
  logic                cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TRIG_W-1:0]   cfg_wdata;

  // Shadow copy of the shape registers, written alongside the unit.
  logic [SHAPE_W-1:0]        shape_q;
  logic [CW-1:0]             center_x_q;
  logic [CW-1:0]             center_y_q;
  logic signed [OFFSET_W-1:0] offset_q;
  logic signed [TRIG_W-1:0]  cos_q;
  logic signed [TRIG_W-1:0]  sin_q;
  logic [CW-1:0]             size_a_q;
  logic [CW-1:0]             size_b_q;

  shaded_word_t predicted_pixels[$];
  shaded_word_t oldest_pixel;
  int           mismatch_count;
  bit           idle_en;

  rotated_shape_pixel_occluder_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_red_in       (in_red_in),
    .in_green_in     (in_green_in),
    .in_blue_in      (in_blue_in),
    .in_mask_in      (in_mask_in),
    .out_valid       (out_valid),
    .out_red_out     (out_red_out),
    .out_green_out   (out_green_out),
    .out_blue_out    (out_blue_out),
    .out_mask_out    (out_mask_out),
    .out_was_blocked (out_was_blocked),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // Free-running clock.
  always #5 clk = ~clk;

  // Round a value with FRAC fraction bits to the nearest pixel, ties upward,
  // and clamp the magnitude beyond any shape extent.
  function automatic longint round_to_pixel(input longint v);
    longint r;
    r = (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
    if (r > SAT) r = SAT;
    if (r < -SAT) r = -SAT;
    return r;
  endfunction

  // Decide whether a pixel is covered by the shape and shade it accordingly.
  function automatic shaded_word_t occlude_pixel(input pixel_word_t p);
    shaded_word_t res;
    longint ox, dx, dy, c, s, ax, ay, a, b;
    bit hit;
    hit = 1'b0;
    if (p.mask) begin
      ox = longint'(center_x_q) + longint'(offset_q);
      dx = longint'(p.x) - ox;
      dy = longint'(p.y) - longint'(center_y_q);
      c  = longint'(cos_q);
      s  = longint'(sin_q);
      ax = round_to_pixel(c * dx + s * dy);
      ay = round_to_pixel(c * dy - s * dx);
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      a = longint'(size_a_q);
      b = longint'(size_b_q);
      case (shape_q)
        SHAPE_BAND:    hit = (2 * ax <= a);
        SHAPE_DISC:    hit = (ax * ax + ay * ay <= a * a);
        SHAPE_ELLIPSE: hit = (a != 0) && (b != 0) &&
                             (ax * ax * b * b + ay * ay * a * a <= a * a * b * b);
        SHAPE_SQUARE:  hit = (2 * ax <= a) && (2 * ay <= a);
        default:       hit = 1'b0;
      endcase
    end
    res.red     = hit ? '0 : p.red;
    res.green   = hit ? '0 : p.green;
    res.blue    = hit ? '0 : p.blue;
    res.mask    = hit ? 1'b0 : p.mask;
    res.blocked = hit;
    return res;
  endfunction

  function automatic pixel_word_t make_pixel(input int x, input int y, input int r,
                                             input int g, input int b, input bit m);
    pixel_word_t p;
    p.x     = x[CW-1:0];
    p.y     = y[CW-1:0];
    p.red   = r[COLOUR_W-1:0];
    p.green = g[COLOUR_W-1:0];
    p.blue  = b[COLOUR_W-1:0];
    p.mask  = m;
    return p;
  endfunction

  function automatic void compare_field(input string name, input logic [COLOUR_W-1:0] exp_v,
                                        input logic [COLOUR_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // Result checker: every strobed word is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (predicted_pixels.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual %0h %0h %0h %0b %0b",
                 $time, out_red_out, out_green_out, out_blue_out, out_mask_out,
                 out_was_blocked);
        mismatch_count++;
      end else begin
        oldest_pixel = predicted_pixels.pop_front();
        compare_field("red", oldest_pixel.red, out_red_out);
        compare_field("green", oldest_pixel.green, out_green_out);
        compare_field("blue", oldest_pixel.blue, out_blue_out);
        compare_field("mask", 8'(oldest_pixel.mask), 8'(out_mask_out));
        compare_field("was_blocked", 8'(oldest_pixel.blocked), 8'(out_was_blocked));
      end
    end
  end

  // Send one pixel word, with a random idle gap in front when enabled.
  task automatic send_pixel(input pixel_word_t p);
    @(negedge clk);
    while (idle_en && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start       <= 1'b1;
    in_pixel_x  <= p.x;
    in_pixel_y  <= p.y;
    in_red_in   <= p.red;
    in_green_in <= p.green;
    in_blue_in  <= p.blue;
    in_mask_in  <= p.mask;
    do @(posedge clk); while (busy !== 1'b0);
    predicted_pixels.push_back(occlude_pixel(p));
  endtask

  // Stop sending and wait until every predicted word has come back.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (predicted_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write one register and keep the shadow copy in step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TRIG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_SHAPE:     shape_q    = data[SHAPE_W-1:0];
      REG_CENTER_X:  center_x_q = data[CW-1:0];
      REG_CENTER_Y:  center_y_q = data[CW-1:0];
      REG_OFFSET_PX: offset_q   = data[OFFSET_W-1:0];
      REG_COS_ROT:   cos_q      = data;
      REG_SIN_ROT:   sin_q      = data;
      REG_SIZE_A:    size_a_q   = data[CW-1:0];
      default:       size_b_q   = data[CW-1:0];
    endcase
  endtask

  // Load a whole shape; unused upper data bits carry random values.
  task automatic load_shape(input int shp, input int cx, input int cy, input int off,
                            input int cs, input int sn, input int a, input int b);
    write_reg(REG_SHAPE,     {13'($urandom), 3'(shp)});
    write_reg(REG_CENTER_X,  {4'($urandom), 12'(cx)});
    write_reg(REG_CENTER_Y,  {4'($urandom), 12'(cy)});
    write_reg(REG_OFFSET_PX, {2'($urandom), 14'(off)});
    write_reg(REG_COS_ROT,   16'(cs));
    write_reg(REG_SIN_ROT,   16'(sn));
    write_reg(REG_SIZE_A,    {4'($urandom), 12'(a)});
    write_reg(REG_SIZE_B,    {4'($urandom), 12'(b)});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Registers straight after reset: no shape, so nothing is blocked.
  task automatic test_reset_defaults();
    send_pixel(make_pixel(0, 0, 255, 255, 255, 1'b1));
    send_pixel(make_pixel(4095, 4095, 0, 0, 0, 1'b1));
    send_pixel(make_pixel(4095, 0, 170, 85, 15, 1'b0));
    wait_drained();
  endtask

  // Band edges on both sides, and a clear mask inside the band.
  task automatic test_band();
    load_shape(SHAPE_BAND, 100, 100, 0, 16384, 0, 20, 0);
    send_pixel(make_pixel(110, 100, 12, 34, 56, 1'b1));
    send_pixel(make_pixel(111, 100, 12, 34, 56, 1'b1));
    send_pixel(make_pixel(90, 4095, 255, 255, 255, 1'b1));
    send_pixel(make_pixel(100, 100, 200, 100, 50, 1'b0));
    wait_drained();
  endtask

  // Disc rim exactly on the radius and one pixel beyond it.
  task automatic test_disc();
    load_shape(SHAPE_DISC, 100, 100, 0, 16384, 0, 10, 0);
    send_pixel(make_pixel(106, 108, 1, 2, 3, 1'b1));
    send_pixel(make_pixel(106, 109, 1, 2, 3, 1'b1));
    wait_drained();
  endtask

  // Ellipse ends of both axes, then a zero second semi-axis.
  task automatic test_ellipse();
    load_shape(SHAPE_ELLIPSE, 100, 100, 0, 16384, 0, 20, 10);
    send_pixel(make_pixel(120, 100, 9, 9, 9, 1'b1));
    send_pixel(make_pixel(100, 110, 9, 9, 9, 1'b1));
    send_pixel(make_pixel(100, 111, 9, 9, 9, 1'b1));
    wait_drained();
    load_shape(SHAPE_ELLIPSE, 100, 100, 0, 16384, 0, 20, 0);
    send_pixel(make_pixel(100, 100, 9, 9, 9, 1'b1));
    wait_drained();
  endtask

  // A half-pixel tie rounds upward: +0.5 leaves the band, -0.5 stays in.
  task automatic test_rounding_ties();
    load_shape(SHAPE_BAND, 100, 100, 0, 8192, 0, 1, 0);
    send_pixel(make_pixel(101, 100, 77, 77, 77, 1'b1));
    send_pixel(make_pixel(99, 100, 77, 77, 77, 1'b1));
    wait_drained();
  endtask

  // Quarter-turn square at the largest size with the origin off the image,
  // then cosine and sine beyond one with the disc at its largest.
  task automatic test_square_and_extremes();
    load_shape(SHAPE_SQUARE, 4095, 0, -4096, 0, 16384, 4095, 4095);
    send_pixel(make_pixel(0, 0, 255, 0, 255, 1'b1));
    send_pixel(make_pixel(2046, 0, 255, 0, 255, 1'b1));
    send_pixel(make_pixel(2047, 0, 255, 0, 255, 1'b1));
    wait_drained();
    load_shape(SHAPE_DISC, 0, 0, 4096, 16'h8000, 16'h7FFF, 4095, 0);
    send_pixel(make_pixel(4095, 4095, 3, 3, 3, 1'b1));
    send_pixel(make_pixel(4095, 1, 3, 3, 3, 1'b1));
    wait_drained();
  endtask

  // Spare shape codes block nothing, even over a huge shape.
  task automatic test_spare_codes();
    load_shape(SHAPE_SPARE_LO, 50, 50, 0, 16384, 0, 4095, 4095);
    send_pixel(make_pixel(50, 50, 128, 128, 128, 1'b1));
    wait_drained();
    load_shape(SHAPE_SPARE_HI, 50, 50, 0, 16384, 0, 4095, 4095);
    send_pixel(make_pixel(50, 50, 128, 128, 128, 1'b1));
    wait_drained();
  endtask

  function automatic int pick_coord();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 4095;
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  function automatic int pick_size();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 4095;
      2, 3:    return $urandom_range(0, 4095);
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  // Pixel aimed near the shape origin most of the time, anywhere otherwise.
  function automatic pixel_word_t random_pixel();
    pixel_word_t p;
    int span, ox;
    p = pixel_word_t'({$urandom, $urandom});
    p.mask = ($urandom_range(0, 99) < 85);
    if ($urandom_range(0, 99) < 75) begin
      span = ((size_a_q > size_b_q) ? int'(size_a_q) : int'(size_b_q)) + 4;
      ox   = int'(center_x_q) + int'(offset_q);
      p.x  = CW'(ox + int'($urandom_range(0, 2 * span)) - span);
      p.y  = CW'(int'(center_y_q) + int'($urandom_range(0, 2 * span)) - span);
    end
    return p;
  endfunction

  // Random scenes: shape, origin, rotation and sizes change between bursts.
  task automatic test_random_scenes();
    int cs, sn, off, shp;
    real ang;
    for (int scene = 0; scene < 20; scene++) begin
      idle_en = !(scene >= 6 && scene <= 9);
      ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
      cs  = $rtoi($floor($cos(ang) * 16384.0 + 0.5));
      sn  = $rtoi($floor($sin(ang) * 16384.0 + 0.5));
      case ($urandom_range(0, 7))
        0: begin
          cs = $urandom_range(0, 65535);
          sn = $urandom_range(0, 65535);
        end
        1: begin
          cs = ($urandom_range(0, 1) != 0) ? 16384 : -16384;
          sn = 0;
        end
        default: ;
      endcase
      off = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16383)
                                        : int'($urandom_range(0, 8192)) - 4096;
      shp = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      load_shape(shp, pick_coord(), pick_coord(), off, cs, sn, pick_size(), pick_size());
      repeat (92) send_pixel(random_pixel());
      wait_drained();
    end
    idle_en = 1'b1;
  endtask

  // Safety net against a hung handshake.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_pixel_x     = '0;
    in_pixel_y     = '0;
    in_red_in      = '0;
    in_green_in    = '0;
    in_blue_in     = '0;
    in_mask_in     = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_SHAPE;
    cfg_wdata      = '0;
    mismatch_count = 0;
    idle_en        = 1'b1;
    shape_q        = SHAPE_NONE;
    center_x_q     = '0;
    center_y_q     = '0;
    offset_q       = '0;
    cos_q          = 16'sd16384;
    sin_q          = '0;
    size_a_q       = '0;
    size_b_q       = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_band();
    test_disc();
    test_ellipse();
    test_rounding_ties();
    test_square_and_extremes();
    test_spare_codes();
    test_random_scenes();

    if (mismatch_count == 0 && predicted_pixels.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
